// ----- rtl/tcw_pkg.sv -----
package tcw_pkg;

  // Default screen geometry
  localparam int DEF_COLS = 80;
  localparam int DEF_ROWS = 25;

  // Fixed port field widths
  localparam int MODE_W    = 2;
  localparam int CHAR_W    = 8;
  localparam int COLOR_W   = 8;
  localparam int ROW_IN_W  = 5;
  localparam int COL_IN_W  = 7;
  localparam int ROW_OUT_W = 5;
  localparam int COL_OUT_W = 7;
  localparam int CELL_W    = CHAR_W + COLOR_W;

  // Character and color constants
  localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0]  SPACE_CODE   = 8'd32;
  localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'd7;

  // Request mode codes
  localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

  // Queue depths between the parts
  localparam int CMDQ_DEPTH = 2;
  localparam int RESQ_DEPTH = 2;

  // Command classes decided by the front end
  typedef enum logic [2:0] {
    CMD_PUT,
    CMD_NEWLINE,
    CMD_CLEAR,
    CMD_READ,
    CMD_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t            kind;
    logic [CHAR_W-1:0]    char_code;
    logic [ROW_IN_W-1:0]  read_row;
    logic [COL_IN_W-1:0]  read_col;
    logic                 rd_ok;
  } cmd_t;

  typedef struct packed {
    logic [ROW_OUT_W-1:0] cursor_row;
    logic [COL_OUT_W-1:0] cursor_col;
    logic [CELL_W-1:0]    cell_value;
    logic                 scrolled;
  } res_t;

endpackage

// ----- rtl/text_console_writer.sv -----
// Channel   Handshake                 Payload
// input     push / full               mode, char_code, read_row, read_col
// result    pop / empty               cursor_row, cursor_col, cell_value, scrolled
// config    color_we                  color_data (text color attribute)
//
// A character, newline, unused mode or out-of-screen read is done in the executor's
// idle state; an in-screen read goes on to the read state (registered memory read).
// A scroll blanks one row through the single memory write port.
// A clear sweeps the whole screen.
// After reset the same whole-screen blanking sweep runs and full stays high.
// A 2-deep request queue and a 2-deep result queue let each side stall alone.
module text_console_writer #(
  parameter int COLS = tcw_pkg::DEF_COLS,
  parameter int ROWS = tcw_pkg::DEF_ROWS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic [tcw_pkg::MODE_W-1:0]     mode,
  input  logic [tcw_pkg::CHAR_W-1:0]     char_code,
  input  logic [tcw_pkg::ROW_IN_W-1:0]   read_row,
  input  logic [tcw_pkg::COL_IN_W-1:0]   read_col,
  output logic                           empty,
  input  logic                           pop,
  output logic [tcw_pkg::ROW_OUT_W-1:0]  cursor_row,
  output logic [tcw_pkg::COL_OUT_W-1:0]  cursor_col,
  output logic [tcw_pkg::CELL_W-1:0]     cell_value,
  output logic                           scrolled,
  input  logic                           color_we,
  input  logic [tcw_pkg::COLOR_W-1:0]    color_data
);

  logic                          front_full;
  logic                          init_busy;
  logic                          take;
  logic                          cmd_valid;
  logic                          cmd_pop;
  tcw_pkg::cmd_t                 cmd;
  logic                          res_full;
  logic                          res_push;
  tcw_pkg::res_t                 res_in;
  tcw_pkg::res_t                 res_out;
  logic [tcw_pkg::COLOR_W-1:0]   text_color;

  // Text color register
  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= tcw_pkg::RESET_COLOR;
    end else if (color_we) begin
      text_color <= color_data;
    end
  end

  // No requests while the screen is being blanked after reset
  assign full = front_full || init_busy;
  assign take = push && !full;

  tcw_front #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .mode      (mode),
    .char_code (char_code),
    .read_row  (read_row),
    .read_col  (read_col),
    .full      (front_full),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  tcw_exec #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_exec (
    .clk        (clk),
    .rst        (rst),
    .text_color (text_color),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res        (res_in),
    .init_busy  (init_busy)
  );

  tcw_resq u_resq (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (pop),
    .empty (empty),
    .dout  (res_out)
  );

  assign cursor_row = res_out.cursor_row;
  assign cursor_col = res_out.cursor_col;
  assign cell_value = res_out.cell_value;
  assign scrolled   = res_out.scrolled;

endmodule

// ----- rtl/tcw_front.sv -----
module tcw_front #(
  parameter int COLS = tcw_pkg::DEF_COLS,
  parameter int ROWS = tcw_pkg::DEF_ROWS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          take,
  input  logic [tcw_pkg::MODE_W-1:0]    mode,
  input  logic [tcw_pkg::CHAR_W-1:0]    char_code,
  input  logic [tcw_pkg::ROW_IN_W-1:0]  read_row,
  input  logic [tcw_pkg::COL_IN_W-1:0]  read_col,
  output logic                          full,
  output logic                          cmd_valid,
  output tcw_pkg::cmd_t                 cmd,
  input  logic                          cmd_pop
);

  localparam int DEPTH = tcw_pkg::CMDQ_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int NW    = $clog2(DEPTH + 1);

  tcw_pkg::cmd_t cmd_in;
  tcw_pkg::cmd_t q [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [NW-1:0] count;

  // Classify the incoming request
  always_comb begin
    cmd_in.char_code = char_code;
    cmd_in.read_row  = read_row;
    cmd_in.read_col  = read_col;
    cmd_in.rd_ok     = (32'(read_row) < ROWS) && (32'(read_col) < COLS);
    case (mode)
      tcw_pkg::MODE_PUT: begin
        cmd_in.kind = (char_code == tcw_pkg::NEWLINE_CODE) ? tcw_pkg::CMD_NEWLINE
                                                           : tcw_pkg::CMD_PUT;
      end
      tcw_pkg::MODE_CLEAR: cmd_in.kind = tcw_pkg::CMD_CLEAR;
      tcw_pkg::MODE_READ:  cmd_in.kind = tcw_pkg::CMD_READ;
      default:             cmd_in.kind = tcw_pkg::CMD_NOP;
    endcase
  end

  // Command queue storage
  always_ff @(posedge clk) begin
    if (take) begin
      q[wr_ptr] <= cmd_in;
    end
  end

  // Queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (take) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (cmd_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (take && !cmd_pop) begin
        count <= count + 1'b1;
      end else if (!take && cmd_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  assign full      = (count == NW'(DEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = q[rd_ptr];

endmodule

// ----- rtl/tcw_exec.sv -----
module tcw_exec #(
  parameter int COLS = tcw_pkg::DEF_COLS,
  parameter int ROWS = tcw_pkg::DEF_ROWS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [tcw_pkg::COLOR_W-1:0]   text_color,
  input  logic                          cmd_valid,
  input  tcw_pkg::cmd_t                 cmd,
  output logic                          cmd_pop,
  input  logic                          res_full,
  output logic                          res_push,
  output tcw_pkg::res_t                 res,
  output logic                          init_busy
);

  localparam int RW     = $clog2(ROWS);
  localparam int CW     = $clog2(COLS);
  localparam int NCELLS = ROWS * COLS;
  localparam int AW     = $clog2(NCELLS);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_FILL = 3'b100
  } exec_state_t;

  exec_state_t state, state_next;

  // Cursor and row rotation
  logic [RW-1:0] row_pos, row_next;
  logic [CW-1:0] col_pos, col_next;
  logic [RW-1:0] base, base_next;
  logic [RW-1:0] row_adv;
  logic [CW-1:0] col_adv;

  // Fill sweep
  logic [AW-1:0]                 fill_addr, fill_addr_next;
  logic [AW-1:0]                 fill_last, fill_last_next;
  logic [tcw_pkg::COLOR_W-1:0]   fill_color, fill_color_next;
  logic                          init_next;

  // Screen memory
  logic [tcw_pkg::CELL_W-1:0] mem [NCELLS];
  logic                       mem_we;
  logic [AW-1:0]              mem_wa;
  logic [tcw_pkg::CELL_W-1:0] mem_wd;
  logic                       mem_re;
  logic [AW-1:0]              mem_ra;
  logic [tcw_pkg::CELL_W-1:0] mem_rdata;

  // Address mapping: physical row = (logical row + base) mod ROWS
  logic [RW:0]   wr_sum;
  logic [RW-1:0] wr_phys;
  logic [AW-1:0] wr_addr;
  logic [RW:0]   rd_sum;
  logic [RW-1:0] rd_phys;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] base_addr;
  logic          scroll;

  assign wr_sum  = {1'b0, row_pos} + {1'b0, base};
  assign wr_phys = (wr_sum >= (RW+1)'(ROWS)) ? RW'(wr_sum - (RW+1)'(ROWS)) : RW'(wr_sum);
  assign wr_addr = AW'(wr_phys * COLS) + AW'(col_pos);

  assign rd_sum  = {1'b0, RW'(cmd.read_row)} + {1'b0, base};
  assign rd_phys = (rd_sum >= (RW+1)'(ROWS)) ? RW'(rd_sum - (RW+1)'(ROWS)) : RW'(rd_sum);
  assign rd_addr = AW'(rd_phys * COLS) + AW'(CW'(cmd.read_col));

  // The oldest physical row becomes the new bottom row on a scroll
  assign base_addr = AW'(base * COLS);

  // Cursor advance for a character or newline
  always_comb begin
    if (cmd.kind == tcw_pkg::CMD_NEWLINE || col_pos == CW'(COLS - 1)) begin
      col_adv = '0;
      row_adv = row_pos + 1'b1;
    end else begin
      col_adv = col_pos + 1'b1;
      row_adv = row_pos;
    end
  end

  // Sequencer
  always_comb begin
    state_next      = state;
    row_next        = row_pos;
    col_next        = col_pos;
    base_next       = base;
    fill_addr_next  = fill_addr;
    fill_last_next  = fill_last;
    fill_color_next = fill_color;
    init_next       = init_busy;
    mem_we          = 1'b0;
    mem_wa          = wr_addr;
    mem_wd          = {text_color, cmd.char_code};
    mem_re          = 1'b0;
    mem_ra          = rd_addr;
    cmd_pop         = 1'b0;
    res_push        = 1'b0;
    scroll          = 1'b0;
    res.cell_value  = '0;

    case (state)
      ST_IDLE: begin
        if (cmd_valid && !res_full) begin
          cmd_pop = 1'b1;
          case (cmd.kind)
            tcw_pkg::CMD_PUT, tcw_pkg::CMD_NEWLINE: begin
              mem_we   = (cmd.kind == tcw_pkg::CMD_PUT);
              col_next = col_adv;
              res_push = 1'b1;
              if (row_adv == RW'(ROWS - 1)) begin
                scroll          = 1'b1;
                row_next        = RW'(ROWS - 2);
                base_next       = (base == RW'(ROWS - 1)) ? '0 : base + 1'b1;
                fill_addr_next  = base_addr;
                fill_last_next  = base_addr + AW'(COLS - 1);
                fill_color_next = text_color;
                state_next      = ST_FILL;
              end else begin
                row_next = row_adv;
              end
            end
            tcw_pkg::CMD_CLEAR: begin
              row_next        = '0;
              col_next        = '0;
              base_next       = '0;
              fill_addr_next  = '0;
              fill_last_next  = AW'(NCELLS - 1);
              fill_color_next = text_color;
              state_next      = ST_FILL;
              res_push        = 1'b1;
            end
            tcw_pkg::CMD_READ: begin
              if (cmd.rd_ok) begin
                mem_re     = 1'b1;
                state_next = ST_READ;
              end else begin
                res_push = 1'b1;
              end
            end
            default: begin
              res_push = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        res_push       = 1'b1;
        res.cell_value = mem_rdata;
        state_next     = ST_IDLE;
      end
      ST_FILL: begin
        mem_we = 1'b1;
        mem_wa = fill_addr;
        mem_wd = {fill_color, tcw_pkg::SPACE_CODE};
        if (fill_addr == fill_last) begin
          state_next = ST_IDLE;
          init_next  = 1'b0;
        end else begin
          fill_addr_next = fill_addr + 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    res.cursor_row = tcw_pkg::ROW_OUT_W'(row_next);
    res.cursor_col = tcw_pkg::COL_OUT_W'(col_next);
    res.scrolled   = scroll;
  end

  // Control registers; reset starts a blanking sweep of the whole screen
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_FILL;
      row_pos    <= '0;
      col_pos    <= '0;
      base       <= '0;
      fill_addr  <= '0;
      fill_last  <= AW'(NCELLS - 1);
      fill_color <= tcw_pkg::RESET_COLOR;
      init_busy  <= 1'b1;
    end else begin
      state      <= state_next;
      row_pos    <= row_next;
      col_pos    <= col_next;
      base       <= base_next;
      fill_addr  <= fill_addr_next;
      fill_last  <= fill_last_next;
      fill_color <= fill_color_next;
      init_busy  <= init_next;
    end
  end

  // Screen memory write port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  // Screen memory read port
  always_ff @(posedge clk) begin
    if (mem_re) begin
      mem_rdata <= mem[mem_ra];
    end
  end

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    32'(row_pos) <= ROWS - 2)
    else $error("cursor row reached the bottom row");

  a_base_range: assert property (@(posedge clk) disable iff (rst)
    32'(base) < ROWS)
    else $error("row rotation offset out of range");

  a_pop_space: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> !res_full)
    else $error("command taken with no room for its result");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FILL) |-> (fill_addr <= fill_last))
    else $error("fill sweep ran past its end");

  a_scroll_next: assert property (@(posedge clk) disable iff (rst)
    (res_push && res.scrolled) |=> (state == ST_FILL && 32'(row_pos) == ROWS - 2))
    else $error("scroll did not start a row blank");

endmodule

// ----- rtl/tcw_resq.sv -----
module tcw_resq (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  tcw_pkg::res_t                  din,
  output logic                           full,
  input  logic                           pop,
  output logic                           empty,
  output tcw_pkg::res_t                  dout
);

  localparam int DEPTH = tcw_pkg::RESQ_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int NW    = $clog2(DEPTH + 1);

  tcw_pkg::res_t q [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [NW-1:0] count;
  logic          take;
  logic          give;

  assign take = push && !full;
  assign give = pop && !empty;

  // Result storage
  always_ff @(posedge clk) begin
    if (take) begin
      q[wr_ptr] <= din;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (take) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (give) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (take && !give) begin
        count <= count + 1'b1;
      end else if (!take && give) begin
        count <= count - 1'b1;
      end
    end
  end

  assign full  = (count == NW'(DEPTH));
  assign empty = (count == '0);
  assign dout  = q[rd_ptr];

endmodule
